>>> design/stsr_pkg.sv
// Shared types, codes and widths for the sorted table block.
// Depends on nothing; every other design file imports it.
`timescale 1ns / 1ps

package stsr_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int VALUE_W  = 32;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 6;
    localparam int HELD_W   = 7;

    // depth of the queue between front and back
    localparam int Q_DEPTH = 2;

    // request type codes on the input port
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // classified operation carried through the queue
    typedef logic [1:0] t_op;
    localparam t_op OP_INSERT = 2'd0;
    localparam t_op OP_SEARCH = 2'd1;
    localparam t_op OP_REMOVE = 2'd2;
    localparam t_op OP_IGNORE = 2'd3;

    typedef struct packed {
        t_op                op;
        logic [VALUE_W-1:0] value;
    } t_item;

    // strobes from the back-end sequencer to the cell row
    typedef struct packed {
        logic cmp;
        logic ins;
        logic rem;
    } t_cell_ctrl;

endpackage

>>> design/stsr_front.sv
// Front end: takes request items, classifies the request type and queues them.
// Depends on stsr_pkg.
`timescale 1ns / 1ps

module stsr_front import stsr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [REQ_W-1:0]   i_req_type,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_in_stall,
    output t_item              o_item,
    output logic               o_item_valid,
    input  logic               i_pop
);

    localparam int PTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int FILL_W = $clog2(Q_DEPTH + 1);

    t_item             r_q [Q_DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [FILL_W-1:0] r_fill, n_fill;
    t_op               w_op;
    logic              w_push;

    always_comb begin
        unique case (i_req_type)
            REQ_INSERT: w_op = OP_INSERT;
            REQ_SEARCH: w_op = OP_SEARCH;
            REQ_REMOVE: w_op = OP_REMOVE;
            default:    w_op = OP_IGNORE;
        endcase
    end

    assign o_in_stall   = (r_fill == FILL_W'(Q_DEPTH));
    assign w_push       = i_in_valid && !o_in_stall;
    assign o_item_valid = (r_fill != '0);
    assign o_item       = r_q[r_rd];

    always_comb begin
        n_wr   = r_wr;
        n_rd   = r_rd;
        n_fill = r_fill;
        if (w_push) begin
            n_wr = (r_wr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !i_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (!w_push && i_pop) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= '{op: w_op, value: i_value};
        end
    end

endmodule

>>> design/stsr_cells.sv
// Row of compare-and-shift cells holding the sorted entries.
// Depends on stsr_pkg.
`timescale 1ns / 1ps

module stsr_cells import stsr_pkg::*; #(
    parameter int unsigned CAPACITY = CAPACITY_DEF,
    localparam int IDX_W = $clog2(CAPACITY),
    localparam int CNT_W = $clog2(CAPACITY + 1)
) (
    input  logic               i_clk,
    input  t_cell_ctrl         i_ctrl,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [CNT_W-1:0]   i_count,
    output logic               o_found,
    output logic [IDX_W-1:0]   o_pos
);

    logic [VALUE_W-1:0]  r_cell [CAPACITY];
    logic [VALUE_W-1:0]  w_prev [CAPACITY];
    logic [VALUE_W-1:0]  w_next [CAPACITY];
    logic [VALUE_W-1:0]  r_val;
    logic [CAPACITY-1:0] r_lt, r_eq;
    logic [CAPACITY-1:0] w_lt, w_eq, w_edge;

    // Held entries are ascending, so r_lt is a thermometer code and w_edge
    // marks the single lower-bound cell (none when all cells hold smaller ones).
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_prev[g] = r_val;
            assign w_edge[g] = ~r_lt[g];
        end else begin : g_rest
            assign w_prev[g] = r_cell[g-1];
            assign w_edge[g] = r_lt[g-1] & ~r_lt[g];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_next[g] = r_cell[g];
        end else begin : g_inner
            assign w_next[g] = r_cell[g+1];
        end

        assign w_lt[g] = (CNT_W'(g) < i_count) &&
                         ($signed(r_cell[g]) < $signed(i_value));
        assign w_eq[g] = (CNT_W'(g) < i_count) && (r_cell[g] == i_value);

        always_ff @(posedge i_clk) begin
            if (i_ctrl.ins && !r_lt[g]) begin
                r_cell[g] <= w_edge[g] ? r_val : w_prev[g];
            end else if (i_ctrl.rem && !r_lt[g]) begin
                r_cell[g] <= w_next[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp) begin
            r_lt  <= w_lt;
            r_eq  <= w_eq;
            r_val <= i_value;
        end
    end

    // one-hot edge to binary index
    always_comb begin
        o_pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            for (int b = 0; b < IDX_W; b++) begin
                if (((i >> b) & 1) != 0) begin
                    o_pos[b] = o_pos[b] | w_edge[i];
                end
            end
        end
    end

    assign o_found = |(w_edge & r_eq);

endmodule

>>> design/stsr_back.sv
// Back end: sequences compare and shift on the cell row, keeps the entry
// count and holds the result register. Depends on stsr_pkg.
`timescale 1ns / 1ps

module stsr_back import stsr_pkg::*; #(
    parameter int unsigned CAPACITY = CAPACITY_DEF,
    localparam int IDX_W = $clog2(CAPACITY),
    localparam int CNT_W = $clog2(CAPACITY + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_item               i_item,
    input  logic                i_item_valid,
    output logic                o_pop,
    output t_cell_ctrl          o_ctrl,
    output logic [CNT_W-1:0]    o_count,
    input  logic                i_found,
    input  logic [IDX_W-1:0]    i_pos,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [POS_W-1:0]    o_position,
    output logic [HELD_W-1:0]   o_entries_held
);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_APPLY = 1'b1;

    logic                r_state, n_state;
    t_op                 r_op, n_op;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [POS_W-1:0]    r_position;
    logic [HELD_W-1:0]   r_held;

    logic                w_load;
    logic [STATUS_W-1:0] w_status;
    logic [IDX_W-1:0]    w_pos;
    logic [IDX_W+POS_W-1:0]  w_pos_ext;
    logic [CNT_W+HELD_W-1:0] w_cnt_ext;

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_count  = r_count;
        o_pop    = 1'b0;
        o_ctrl   = '0;
        w_load   = 1'b0;
        w_status = ST_NOT_FOUND;
        w_pos    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    o_pop      = 1'b1;
                    o_ctrl.cmp = 1'b1;
                    n_op       = i_item.op;
                    n_state    = S_APPLY;
                end
            end
            S_APPLY: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                    unique case (r_op)
                        OP_INSERT: begin
                            if (r_count == CNT_W'(CAPACITY)) begin
                                w_status = ST_FULL;
                            end else begin
                                w_status   = ST_DONE;
                                w_pos      = i_pos;
                                o_ctrl.ins = 1'b1;
                                n_count    = r_count + 1'b1;
                            end
                        end
                        OP_SEARCH: begin
                            if (i_found) begin
                                w_status = ST_DONE;
                                w_pos    = i_pos;
                            end
                        end
                        OP_REMOVE: begin
                            if (i_found) begin
                                w_status   = ST_DONE;
                                w_pos      = i_pos;
                                o_ctrl.rem = 1'b1;
                                n_count    = r_count - 1'b1;
                            end
                        end
                        default: begin
                            w_status = ST_NOT_FOUND;
                        end
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign w_pos_ext = {{POS_W{1'b0}}, w_pos};
    assign w_cnt_ext = {{HELD_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_IGNORE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_status   <= w_status;
            r_position <= w_pos_ext[POS_W-1:0];
            r_held     <= w_cnt_ext[HELD_W-1:0];
        end
    end

    assign o_count        = r_count;
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_position     = r_position;
    assign o_entries_held = r_held;

endmodule

>>> design/sorted_table_insert_search_remove.sv
// Sorted table: an accepted item goes through the queue and the compare
// registers into the output register. The next compare waits for the shift
// across the cell row, since it needs the shifted entries.
// Reset (synchronous, active low) empties the queue and the output register
// and zeroes the entry count; cell contents are left as they are.
`timescale 1ns / 1ps

module sorted_table_insert_search_remove import stsr_pkg::*; #(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [VALUE_W-1:0]  i_value,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [POS_W-1:0]    o_position,
    output logic [HELD_W-1:0]   o_entries_held
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_item            w_item;
    logic             w_item_valid;
    logic             w_pop;
    t_cell_ctrl       w_ctrl;
    logic [CNT_W-1:0] w_count;
    logic             w_found;
    logic [IDX_W-1:0] w_pos;

    // Front: decode the request type and park the item in a short queue,
    // so the sender is only held off when two items are waiting.
    stsr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_req_type   (i_req_type),
        .i_value      (i_value),
        .o_in_stall   (o_in_stall),
        .o_item       (w_item),
        .o_item_valid (w_item_valid),
        .i_pop        (w_pop)
    );

    // Cell row: every held entry compares against the queue head in
    // parallel; the registered results find the lower bound and drive the
    // one-step shift for insert or remove.
    stsr_cells #(
        .CAPACITY (CAPACITY)
    ) u_cells (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_value (w_item.value),
        .i_count (w_count),
        .o_found (w_found),
        .o_pos   (w_pos)
    );

    // Back: compare, then decide, shift and load the result register together
    // (waits in the decide state while the last result is not yet taken).
    stsr_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (w_item),
        .i_item_valid   (w_item_valid),
        .o_pop          (w_pop),
        .o_ctrl         (w_ctrl),
        .o_count        (w_count),
        .i_found        (w_found),
        .i_pos          (w_pos),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_position     (o_position),
        .o_entries_held (o_entries_held)
    );

    // the back never takes an item from an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_item_valid)
        else $error("item taken from empty queue");

    // compare, insert shift and remove shift never overlap
    a_ctrl_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_ctrl.cmp, w_ctrl.ins, w_ctrl.rem}))
        else $error("cell row strobes overlap");

    // a compare is always followed by the decide state before the next one
    a_cmp_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.cmp |=> !w_ctrl.cmp)
        else $error("back-to-back compares on the cell row");

    // a remove shift only happens on a matching entry
    a_rem_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.rem |-> w_found)
        else $error("remove shift without a match");

endmodule
